[design/fra_pkg.sv]
package fra_pkg;

    // Field widths and header layout.
    localparam int LEN_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int HDR_BYTES = 4;
    localparam int HC_W      = 3;
    localparam int CNT_W     = LEN_W + 1;
    localparam int SUM_W     = LEN_W + 2;
    localparam int STAT_W    = 3;
    localparam int TDATA_W   = 88;
    localparam int TUSER_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Per-frame header fault codes.
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_ORDER = 2'd1;
    localparam logic [1:0] FAULT_ID    = 2'd2;

    // Status codes reported at frame end.
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_DONE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_SHORT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_ORDER  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ID     = 3'd4;
    localparam logic [STAT_W-1:0] ST_TOOBIG = 3'd5;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_MASK = 1'b1;
    localparam logic [LEN_W-1:0]     CAP_RESET     = 16'd4096;
    localparam logic [BYTE_W-1:0]    MASK_RESET    = 8'd1;

    typedef struct packed {
        logic [LEN_W-1:0]  capacity;
        logic [BYTE_W-1:0] last_mask;
    } t_cfg;

    typedef struct packed {
        logic              write_valid;
        logic [LEN_W-1:0]  write_addr;
        logic [BYTE_W-1:0] write_data;
        logic              status_valid;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  message_length;
        logic [BYTE_W-1:0] message_flags;
        logic [BYTE_W-1:0] frag_id;
        logic [BYTE_W-1:0] frag_flags;
        logic [LEN_W-1:0]  frag_index;
    } t_result;

endpackage

[design/fra_cfg.sv]
module fra_cfg
    import fra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_addr,
    input  logic [LEN_W-1:0]     i_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register file for capacity and last-fragment mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity  <= CAP_RESET;
            r_cfg.last_mask <= MASK_RESET;
        end else if (i_wr) begin
            case (i_addr)
                CFG_CAPACITY:  r_cfg.capacity  <= i_wdata;
                CFG_LAST_MASK: r_cfg.last_mask <= i_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/fra_core.sv]
module fra_core
    import fra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_frame_end,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    // Per-frame state.
    logic [HC_W-1:0]   r_header_count, n_header_count;
    logic [BYTE_W-1:0] r_head_id, n_head_id;
    logic [BYTE_W-1:0] r_head_flags, n_head_flags;
    logic [LEN_W-1:0]  r_head_index, n_head_index;
    logic [1:0]        r_frame_fault, n_frame_fault;
    logic [CNT_W-1:0]  r_payload_count, n_payload_count;

    // Message state.
    logic              r_active, n_active;
    logic [BYTE_W-1:0] r_message_id, n_message_id;
    logic [BYTE_W-1:0] r_stored_flags, n_stored_flags;
    logic [LEN_W-1:0]  r_stored_length, n_stored_length;
    logic [LEN_W-1:0]  r_expected_index, n_expected_index;

    logic              in_header;
    logic              hdr_last;
    logic              is_short;
    logic [CNT_W-1:0]  count_bump;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  addr;
    logic [SUM_W-1:0]  total;
    logic [SUM_W-1:0]  cap_ext;
    logic [LEN_W-1:0]  hdr_index;
    logic [1:0]        hdr_fault;
    t_result           res;

    assign in_header  = (r_header_count < HC_W'(HDR_BYTES));
    assign hdr_last   = (r_header_count == HC_W'(HDR_BYTES - 1));
    assign is_short   = in_header && !hdr_last;
    assign count_bump = (r_payload_count != CNT_MAX) ? r_payload_count + 1'b1 : r_payload_count;
    assign base       = r_active ? SUM_W'(r_stored_length) : '0;
    assign addr       = base + SUM_W'(r_payload_count);
    assign total      = base + SUM_W'(in_header ? r_payload_count : count_bump);
    assign cap_ext    = SUM_W'(i_cfg.capacity);

    // The index as completed by the last header byte.
    assign hdr_index  = {i_data_byte, r_head_index[BYTE_W-1:0]};

    // Header check, using the header fields as completed by this byte.
    always_comb begin
        if (!r_active) begin
            hdr_fault = (hdr_index != '0) ? FAULT_ORDER : FAULT_NONE;
        end else if (r_head_id != r_message_id) begin
            hdr_fault = FAULT_ID;
        end else if (hdr_index != r_expected_index) begin
            hdr_fault = FAULT_ORDER;
        end else begin
            hdr_fault = FAULT_NONE;
        end
    end

    // Next state and result for one byte.
    always_comb begin
        n_header_count   = r_header_count;
        n_head_id        = r_head_id;
        n_head_flags     = r_head_flags;
        n_head_index     = r_head_index;
        n_frame_fault    = r_frame_fault;
        n_payload_count  = r_payload_count;
        n_active         = r_active;
        n_message_id     = r_message_id;
        n_stored_flags   = r_stored_flags;
        n_stored_length  = r_stored_length;
        n_expected_index = r_expected_index;
        res              = '0;

        if (in_header) begin
            case (r_header_count)
                HC_W'(0): n_head_id    = i_data_byte;
                HC_W'(1): n_head_flags = i_data_byte;
                HC_W'(2): n_head_index = {{(LEN_W - BYTE_W){1'b0}}, i_data_byte};
                default:  n_head_index = {i_data_byte, r_head_index[BYTE_W-1:0]};
            endcase
            n_header_count = r_header_count + 1'b1;
            if (hdr_last) begin
                n_frame_fault = hdr_fault;
            end
        end else begin
            if (r_frame_fault == FAULT_NONE && addr < cap_ext) begin
                res.write_valid = 1'b1;
                res.write_addr  = addr[LEN_W-1:0];
                res.write_data  = i_data_byte;
            end
            n_payload_count = count_bump;
        end

        if (i_frame_end) begin
            res.status_valid = 1'b1;
            if (is_short) begin
                res.status = ST_SHORT;
            end else begin
                res.frag_id    = n_head_id;
                res.frag_flags = n_head_flags;
                res.frag_index = n_head_index;
                if (n_frame_fault == FAULT_ORDER || n_frame_fault == FAULT_ID
                        || total > cap_ext) begin
                    n_active         = 1'b0;
                    n_message_id     = '0;
                    n_stored_flags   = '0;
                    n_stored_length  = '0;
                    n_expected_index = '0;
                    if (n_frame_fault == FAULT_ORDER) begin
                        res.status = ST_ORDER;
                    end else if (n_frame_fault == FAULT_ID) begin
                        res.status = ST_ID;
                    end else begin
                        res.status = ST_TOOBIG;
                    end
                end else begin
                    if (!r_active) begin
                        n_message_id   = n_head_id;
                        n_stored_flags = n_head_flags;
                    end
                    n_stored_length  = total[LEN_W-1:0];
                    n_expected_index = n_head_index + 1'b1;
                    if ((n_head_flags & i_cfg.last_mask) != '0) begin
                        n_stored_flags = n_head_flags;
                        n_active       = 1'b0;
                        res.status     = ST_DONE;
                    end else begin
                        n_active   = 1'b1;
                        res.status = ST_OK;
                    end
                end
            end
            res.message_length = n_stored_length;
            res.message_flags  = n_stored_flags;

            // Every frame end starts the next frame from scratch.
            n_header_count  = '0;
            n_head_id       = '0;
            n_head_flags    = '0;
            n_head_index    = '0;
            n_frame_fault   = FAULT_NONE;
            n_payload_count = '0;
        end
    end

    // State registers advance once per byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count   <= '0;
            r_head_id        <= '0;
            r_head_flags     <= '0;
            r_head_index     <= '0;
            r_frame_fault    <= FAULT_NONE;
            r_payload_count  <= '0;
            r_active         <= 1'b0;
            r_message_id     <= '0;
            r_stored_flags   <= '0;
            r_stored_length  <= '0;
            r_expected_index <= '0;
        end else if (i_step) begin
            r_header_count   <= n_header_count;
            r_head_id        <= n_head_id;
            r_head_flags     <= n_head_flags;
            r_head_index     <= n_head_index;
            r_frame_fault    <= n_frame_fault;
            r_payload_count  <= n_payload_count;
            r_active         <= n_active;
            r_message_id     <= n_message_id;
            r_stored_flags   <= n_stored_flags;
            r_stored_length  <= n_stored_length;
            r_expected_index <= n_expected_index;
        end
    end

    assign o_result = res;

    // The header counter never runs past the header length.
    a_hc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_count <= HC_W'(HDR_BYTES))
        else $error("header count beyond header length");

    // A frame end leaves the per-frame state empty.
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_frame_end |=> r_header_count == '0 && r_payload_count == '0
            && r_frame_fault == FAULT_NONE)
        else $error("frame state not cleared after frame end");

    // A short frame leaves the message untouched.
    a_short_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_frame_end && is_short |=> $stable(r_active)
            && $stable(r_stored_length) && $stable(r_expected_index))
        else $error("short frame changed message state");

    // Payload writes only happen after the header is complete.
    a_write_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.write_valid |-> !in_header && r_frame_fault == FAULT_NONE)
        else $error("buffer write during header or faulted frame");

endmodule

[design/fragment_reassembler_top.sv]
// Channel   Direction  Beat contents
// s_axis    in         tdata[7:0] data_byte; tlast frame_end
// m_axis    out        tuser: write_valid, status_valid; tdata: write and status fields
// cfg       in         addr 0 capacity, addr 1 last_flag_mask; wdata[15:0]
//
// One byte is taken per cycle while m_axis does not stall the output register.
// The input register feeds one combinational step of the reassembly state into the
// output register. Reset is synchronous and active low; it loads capacity 4096 and
// mask 1 and clears all frame and message state. A stall on m_axis holds the output
// register and then the input register; s_axis tready falls only when both are full.
module fragment_reassembler_top
    import fra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,   // [7:0] data_byte
    input  logic                 i_s_tlast,   // frame_end
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [15:0] write_addr, [23:16] write_data, [26:24] status, [42:27] message_length,
    // [50:43] message_flags, [58:51] frag_id, [66:59] frag_flags, [82:67] frag_index
    output logic [TDATA_W-1:0]   o_m_tdata,
    output logic [TUSER_W-1:0]   o_m_tuser,   // [0] write_valid, [1] status_valid
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [LEN_W-1:0]     i_cfg_wdata
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    logic              advance;
    logic              s_accept;
    t_cfg              cfg;
    t_result           result;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    fra_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    fra_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_in_valid && advance),
        .i_data_byte (r_in_data),
        .i_frame_end (r_in_last),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input and output payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance && r_in_valid) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = {r_out.status_valid, r_out.write_valid};
    assign o_m_tdata  = {5'b0, r_out.frag_index, r_out.frag_flags, r_out.frag_id,
                         r_out.message_flags, r_out.message_length, r_out.status,
                         r_out.write_data, r_out.write_addr};

endmodule
